### rtl/ocr_pkg.sv
// Shared types, constants and the path table of the orthogonal connector router.
`default_nettype none

package ocr_pkg;

   localparam int GRID_STEP_DEF  = 60;
   localparam int COORD_BITS_DEF = 12;
   localparam int IN_BITS        = 12;
   localparam int POINT_BITS     = 13;
   localparam int POINT_MAX      = 8191;
   localparam int NUM_SECTORS    = 8;
   localparam int MAX_WAYPOINTS  = 6;
   localparam int IDX_BITS       = $clog2(MAX_WAYPOINTS);
   localparam int COUNT_BITS     = $clog2(MAX_WAYPOINTS + 1);

   // Y grows downward: "up" means end_y < start_y.
   typedef enum logic [2:0] {
      SECT_RIGHT      = 3'd0,
      SECT_UP_RIGHT   = 3'd1,
      SECT_UP         = 3'd2,
      SECT_UP_LEFT    = 3'd3,
      SECT_LEFT       = 3'd4,
      SECT_DOWN_LEFT  = 3'd5,
      SECT_DOWN       = 3'd6,
      SECT_DOWN_RIGHT = 3'd7
   } sector_type;

   // Coordinate source of a waypoint: endpoint a (start) or b (end), raw or snapped.
   typedef enum logic [2:0] {
      SRC_A    = 3'd0,
      SRC_A_UP = 3'd1,
      SRC_A_DN = 3'd2,
      SRC_B    = 3'd3,
      SRC_B_UP = 3'd4,
      SRC_B_DN = 3'd5
   } src_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0]            count;
      src_type [MAX_WAYPOINTS-1:0]      xs;
      src_type [MAX_WAYPOINTS-1:0]      ys;
   } route_type;

   typedef struct packed {
      logic [IN_BITS-1:0] start_x;
      logic [IN_BITS-1:0] start_y;
      logic [IN_BITS-1:0] end_x;
      logic [IN_BITS-1:0] end_y;
   } req_type;

   typedef struct packed {
      logic [POINT_BITS-1:0] point_x;
      logic [POINT_BITS-1:0] point_y;
      logic                  is_move;
      logic                  last_point;
      logic                  bad_input;
   } rsp_type;

   function automatic route_type route_of(input sector_type sect);
      route_type r;
      for (int k = 0; k < MAX_WAYPOINTS; k++) begin
         r.xs[k] = SRC_A;
         r.ys[k] = SRC_A;
      end
      r.count = COUNT_BITS'(MAX_WAYPOINTS);
      unique case (sect)
         SECT_UP: begin
            r.count = COUNT_BITS'(2);
            r.xs[1] = SRC_B;
            r.ys[1] = SRC_B;
         end
         SECT_UP_RIGHT, SECT_UP_LEFT: begin
            r.count = COUNT_BITS'(4);
            r.xs[2] = SRC_B;
            r.xs[3] = SRC_B;
            r.ys[1] = SRC_B_UP;
            r.ys[2] = SRC_B_UP;
            r.ys[3] = SRC_B;
         end
         SECT_LEFT, SECT_DOWN_LEFT: begin
            r.xs[2] = SRC_B_UP;
            r.xs[3] = SRC_B_UP;
            r.xs[4] = SRC_B;
            r.xs[5] = SRC_B;
            r.ys[1] = SRC_A_DN;
            r.ys[2] = SRC_A_DN;
            r.ys[3] = SRC_B_UP;
            r.ys[4] = SRC_B_UP;
            r.ys[5] = SRC_B;
         end
         SECT_RIGHT, SECT_DOWN, SECT_DOWN_RIGHT: begin
            r.xs[2] = SRC_B_DN;
            r.xs[3] = SRC_B_DN;
            r.xs[4] = SRC_B;
            r.xs[5] = SRC_B;
            r.ys[1] = SRC_A_DN;
            r.ys[2] = SRC_A_DN;
            r.ys[3] = SRC_B_UP;
            r.ys[4] = SRC_B_UP;
            r.ys[5] = SRC_B;
         end
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/ocr_if.sv
// Valid/ready channel interfaces for connection requests and waypoint responses.
`default_nettype none

interface ocr_req_if;
   logic             valid;
   logic             ready;
   ocr_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface ocr_rsp_if;
   logic             valid;
   logic             ready;
   ocr_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/orthogonal_connector_router.sv
// Orthogonal connector router: endpoint pair in, grid-snapped waypoint stream out.
//
// req_ch carries one connection (start_x/y, end_x/y); rsp_ch returns its
// waypoints in order, one transfer each: the first has is_move set, the
// final one has last_point set. A connection gives 2, 4 or 6 waypoints by
// the sector of end relative to start; coinciding endpoints give a single
// transfer with bad_input and last_point set and a zero point.
// Pipeline: a capture stage (reciprocal multiply for the grid quotient), a
// path stage (grid floor, sector) that steps through the waypoints, and an
// output register; a request passes through them in that order. Waypoints
// follow one per cycle while rsp_ch.ready stays high. The path stage emits one
// waypoint per cycle while the output can take it, and holds a connection
// until its last waypoint (1 to 6 in all) is loaded; the capture stage takes
// the next request while the current one is still emitting.
// When rsp_ch.ready is low the output holds and the stages fill up; req_ch.ready
// drops once the capture stage is occupied and cannot move on.
// Synchronous reset empties all stages; no state survives a connection.
`default_nettype none

module orthogonal_connector_router #(
   parameter int GRID_STEP  = ocr_pkg::GRID_STEP_DEF,
   parameter int COORD_BITS = ocr_pkg::COORD_BITS_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   ocr_req_if.sink    req_ch,
   ocr_rsp_if.source  rsp_ch
);

   localparam int CW = (COORD_BITS < ocr_pkg::IN_BITS) ? COORD_BITS : ocr_pkg::IN_BITS;
   localparam int RECIP = (1 << CW) / GRID_STEP;
   localparam logic [CW-1:0] RECIP_V = CW'(RECIP);

   // coordinate slots: start_x, start_y, end_x, end_y
   logic [CW-1:0]   req_c [4];
   logic [2*CW-1:0] prod  [4];

   logic            s1_valid_ff, s1_valid_in;
   logic [CW-1:0]   s1_c_ff [4];
   logic [CW-1:0]   s1_q_ff [4];

   logic [CW-1:0]   gf [4];
   logic            rz [4];
   ocr_pkg::sector_type sect;
   logic            bad;

   logic                         s2_valid_ff, s2_valid_in;
   logic [CW-1:0]                s2_c_ff  [4];
   logic [CW-1:0]                s2_gf_ff [4];
   logic                         s2_rz_ff [4];
   ocr_pkg::sector_type          s2_sect_ff;
   logic                         s2_bad_ff;
   logic [ocr_pkg::IDX_BITS-1:0] idx_ff, idx_in;

   ocr_pkg::route_type           route;
   logic [ocr_pkg::POINT_BITS-1:0] px;
   logic [ocr_pkg::POINT_BITS-1:0] py;

   logic             rsp_valid_ff, rsp_valid_in;
   ocr_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic req_fire;
   logic out_load;
   logic s2_last;
   logic s2_free;
   logic s1_free;
   logic s1_adv;

   // ---------------- capture stage ----------------
   assign req_c[0] = req_ch.payload.start_x[CW-1:0];
   assign req_c[1] = req_ch.payload.start_y[CW-1:0];
   assign req_c[2] = req_ch.payload.end_x[CW-1:0];
   assign req_c[3] = req_ch.payload.end_y[CW-1:0];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         prod[i] = {{CW{1'b0}}, req_c[i]} * {{CW{1'b0}}, RECIP_V};
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         for (int i = 0; i < 4; i++) begin
            s1_c_ff[i] <= req_c[i];
            s1_q_ff[i] <= prod[i][2*CW-1:CW];
         end
      end
   end

   // ---------------- path stage ----------------
   for (genvar g = 0; g < 4; g++) begin : g_grid
      ocr_grid #(
         .GRID_STEP  (GRID_STEP),
         .COORD_BITS (CW)
      ) u_grid (
         .coord     (s1_c_ff[g]),
         .quot      (s1_q_ff[g]),
         .floor_val (gf[g]),
         .on_grid   (rz[g])
      );
   end

   assign bad = (s1_c_ff[0] == s1_c_ff[2]) && (s1_c_ff[1] == s1_c_ff[3]);

   always_comb begin
      priority if (s1_c_ff[3] == s1_c_ff[1]) begin
         sect = (s1_c_ff[2] > s1_c_ff[0]) ? ocr_pkg::SECT_RIGHT : ocr_pkg::SECT_LEFT;
      end else if (s1_c_ff[3] < s1_c_ff[1]) begin
         priority if (s1_c_ff[2] > s1_c_ff[0]) sect = ocr_pkg::SECT_UP_RIGHT;
         else if (s1_c_ff[2] == s1_c_ff[0])    sect = ocr_pkg::SECT_UP;
         else                                  sect = ocr_pkg::SECT_UP_LEFT;
      end else begin
         priority if (s1_c_ff[2] < s1_c_ff[0]) sect = ocr_pkg::SECT_DOWN_LEFT;
         else if (s1_c_ff[2] == s1_c_ff[0])    sect = ocr_pkg::SECT_DOWN;
         else                                  sect = ocr_pkg::SECT_DOWN_RIGHT;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         for (int i = 0; i < 4; i++) begin
            s2_c_ff[i]  <= s1_c_ff[i];
            s2_gf_ff[i] <= gf[i];
            s2_rz_ff[i] <= rz[i];
         end
         s2_sect_ff <= sect;
         s2_bad_ff  <= bad;
      end
   end

   assign route = ocr_pkg::route_of(s2_sect_ff);

   ocr_pick #(
      .GRID_STEP  (GRID_STEP),
      .COORD_BITS (CW)
   ) u_pick_x (
      .code    (route.xs[idx_ff]),
      .coord_a (s2_c_ff[0]),
      .floor_a (s2_gf_ff[0]),
      .grid_a  (s2_rz_ff[0]),
      .coord_b (s2_c_ff[2]),
      .floor_b (s2_gf_ff[2]),
      .grid_b  (s2_rz_ff[2]),
      .point   (px)
   );

   ocr_pick #(
      .GRID_STEP  (GRID_STEP),
      .COORD_BITS (CW)
   ) u_pick_y (
      .code    (route.ys[idx_ff]),
      .coord_a (s2_c_ff[1]),
      .floor_a (s2_gf_ff[1]),
      .grid_a  (s2_rz_ff[1]),
      .coord_b (s2_c_ff[3]),
      .floor_b (s2_gf_ff[3]),
      .grid_b  (s2_rz_ff[3]),
      .point   (py)
   );

   // ---------------- flow control ----------------
   assign out_load = s2_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign s2_last  = s2_bad_ff || (idx_ff == ocr_pkg::IDX_BITS'(route.count - 1'b1));
   assign s2_free  = !s2_valid_ff || (out_load && s2_last);
   assign s1_adv   = s1_valid_ff && s2_free;
   assign s1_free  = !s1_valid_ff || s2_free;
   assign req_fire = req_ch.valid && s1_free;

   assign req_ch.ready = s1_free;

   always_comb begin
      s1_valid_in  = req_fire || (s1_valid_ff && !s2_free);
      s2_valid_in  = s2_free ? s1_valid_ff : 1'b1;
      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ch.ready);
      if (s1_adv) begin
         idx_in = '0;
      end else if (out_load) begin
         idx_in = idx_ff + 1'b1;
      end else begin
         idx_in = idx_ff;
      end
   end

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (out_load) begin
         if (s2_bad_ff) begin
            rsp_data_in.point_x    = '0;
            rsp_data_in.point_y    = '0;
            rsp_data_in.is_move    = 1'b0;
            rsp_data_in.last_point = 1'b1;
            rsp_data_in.bad_input  = 1'b1;
         end else begin
            rsp_data_in.point_x    = px;
            rsp_data_in.point_y    = py;
            rsp_data_in.is_move    = (idx_ff == '0);
            rsp_data_in.last_point = s2_last;
            rsp_data_in.bad_input  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

   // ---------------- assertions ----------------
   a_bad_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.payload.bad_input
         |-> rsp_ch.payload.last_point && !rsp_ch.payload.is_move)
      else $error("bad_input transfer must be a lone final transfer");

   a_move_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.payload.is_move |-> !rsp_ch.payload.last_point)
      else $error("a path cannot end on its move point");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !s2_bad_ff |-> (ocr_pkg::COUNT_BITS'(idx_ff) < route.count))
      else $error("waypoint index past end of path");

endmodule

`default_nettype wire

### rtl/ocr_grid.sv
// Grid floor of one coordinate from an estimated quotient, with one-step correction.
`default_nettype none

module ocr_grid #(
   parameter int GRID_STEP  = ocr_pkg::GRID_STEP_DEF,
   parameter int COORD_BITS = ocr_pkg::COORD_BITS_DEF
) (
   input  wire logic [COORD_BITS-1:0] coord,
   input  wire logic [COORD_BITS-1:0] quot,
   output logic      [COORD_BITS-1:0] floor_val,
   output logic                       on_grid
);

   localparam int GW = $clog2(GRID_STEP + 1);
   localparam int MW = (COORD_BITS > GW) ? COORD_BITS : GW;
   localparam int EW = (MW + 1 > ocr_pkg::POINT_BITS) ? MW + 1 : ocr_pkg::POINT_BITS;
   localparam logic [EW-1:0] STEP = EW'(GRID_STEP);

   logic [COORD_BITS+GW-1:0] prod;
   logic [COORD_BITS-1:0]    est;
   logic [EW-1:0]            rem;
   logic                     over;

   // est is quot*step with quot one short at most, so the remainder is below 2*step
   assign prod      = {{GW{1'b0}}, quot} * (COORD_BITS + GW)'(GRID_STEP);
   assign est       = prod[COORD_BITS-1:0];
   assign rem       = EW'(coord) - EW'(est);
   assign over      = (rem >= STEP);
   assign floor_val = over ? COORD_BITS'(EW'(est) + STEP) : est;
   assign on_grid   = (rem == '0) || (rem == STEP);

endmodule

`default_nettype wire

### rtl/ocr_pick.sv
// Selects one waypoint coordinate from the endpoints and their snapped values.
`default_nettype none

module ocr_pick #(
   parameter int GRID_STEP  = ocr_pkg::GRID_STEP_DEF,
   parameter int COORD_BITS = ocr_pkg::COORD_BITS_DEF
) (
   input  wire ocr_pkg::src_type              code,
   input  wire logic [COORD_BITS-1:0]         coord_a,
   input  wire logic [COORD_BITS-1:0]         floor_a,
   input  wire logic                          grid_a,
   input  wire logic [COORD_BITS-1:0]         coord_b,
   input  wire logic [COORD_BITS-1:0]         floor_b,
   input  wire logic                          grid_b,
   output logic      [ocr_pkg::POINT_BITS-1:0] point
);

   localparam int GW = $clog2(GRID_STEP + 1);
   localparam int MW = (COORD_BITS > GW) ? COORD_BITS : GW;
   localparam int EW = (MW + 1 > ocr_pkg::POINT_BITS) ? MW + 1 : ocr_pkg::POINT_BITS;
   localparam logic [EW-1:0] STEP = EW'(GRID_STEP);
   localparam logic [EW-1:0] SAT  = EW'(ocr_pkg::POINT_MAX);

   logic [EW-1:0] up_a;
   logic [EW-1:0] dn_a;
   logic [EW-1:0] up_b;
   logic [EW-1:0] dn_b;
   logic [EW-1:0] val;

   // snap down: strictly below, so a coordinate on a grid line drops one step (never below 0)
   assign up_a = EW'(floor_a) + STEP;
   assign up_b = EW'(floor_b) + STEP;
   assign dn_a = !grid_a ? EW'(floor_a) : ((floor_a == '0) ? '0 : EW'(floor_a) - STEP);
   assign dn_b = !grid_b ? EW'(floor_b) : ((floor_b == '0) ? '0 : EW'(floor_b) - STEP);

   always_comb begin
      unique case (code)
         ocr_pkg::SRC_A:    val = EW'(coord_a);
         ocr_pkg::SRC_A_UP: val = up_a;
         ocr_pkg::SRC_A_DN: val = dn_a;
         ocr_pkg::SRC_B:    val = EW'(coord_b);
         ocr_pkg::SRC_B_UP: val = up_b;
         default:           val = dn_b;
      endcase
   end

   assign point = (val > SAT) ? ocr_pkg::POINT_BITS'(ocr_pkg::POINT_MAX)
                              : val[ocr_pkg::POINT_BITS-1:0];

endmodule

`default_nettype wire

### tb/orthogonal_connector_router_tb.sv
// Self-checking testbench for the orthogonal connector router: driver, monitor, route predictor.
module orthogonal_connector_router_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ocr_pkg::*;

   localparam int GRID          = GRID_STEP_DEF;
   localparam int LONG_HOLD     = 150;
   localparam int QUIET_LIMIT   = 3000;
   localparam int PHASE_ITEMS   = 45;
   localparam int DRAIN_CYCLES  = 12;

   logic clock;
   logic reset;

   ocr_req_if req_ch ();
   ocr_rsp_if rsp_ch ();

   orthogonal_connector_router dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   req_type pending_requests[$];
   rsp_type waypoints_due[$];

   int send_idle_pct;
   int recv_stall_pct;
   int holds_asked;
   int holds_served;
   int hold_left;
   bit req_taken;
   int quiet_cycles;
   int errors;
   int connections;
   int coincident;
   int waypoints_checked;
   int input_stalls;
   int sector_hits[NUM_SECTORS];

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b0;
      forever #5 clock = ~clock;
   end

   // grid line strictly above / strictly below, clipped to the point width
   function automatic logic [POINT_BITS-1:0] coord_from(input src_type s, input int a,
                                                       input int b);
      int v;
      case (s)
         SRC_A:    v = a;
         SRC_A_UP: v = (a / GRID + 1) * GRID;
         SRC_A_DN: v = (a == 0) ? 0 : ((a - 1) / GRID) * GRID;
         SRC_B:    v = b;
         SRC_B_UP: v = (b / GRID + 1) * GRID;
         default:  v = (b == 0) ? 0 : ((b - 1) / GRID) * GRID;
      endcase
      if (v > POINT_MAX) v = POINT_MAX;
      return POINT_BITS'(v);
   endfunction

   function automatic void plan_route(input req_type r);
      int x1, y1, x2, y2, n;
      sector_type sect;
      src_type xs[MAX_WAYPOINTS];
      src_type ys[MAX_WAYPOINTS];
      rsp_type w;
      x1 = int'(r.start_x);
      y1 = int'(r.start_y);
      x2 = int'(r.end_x);
      y2 = int'(r.end_y);
      connections++;
      if (x1 == x2 && y1 == y2) begin
         coincident++;
         w = '0;
         w.last_point = 1'b1;
         w.bad_input = 1'b1;
         waypoints_due.push_back(w);
         return;
      end
      if (y2 == y1) sect = (x2 > x1) ? SECT_RIGHT : SECT_LEFT;
      else if (y2 < y1) sect = (x2 > x1) ? SECT_UP_RIGHT : (x2 == x1) ? SECT_UP : SECT_UP_LEFT;
      else sect = (x2 < x1) ? SECT_DOWN_LEFT : (x2 == x1) ? SECT_DOWN : SECT_DOWN_RIGHT;
      sector_hits[sect]++;
      ys = '{SRC_A, SRC_A_DN, SRC_A_DN, SRC_B_UP, SRC_B_UP, SRC_B};
      case (sect)
         SECT_UP: begin
            n = 2;
            xs = '{SRC_A, SRC_B, SRC_A, SRC_A, SRC_A, SRC_A};
            ys = '{SRC_A, SRC_B, SRC_A, SRC_A, SRC_A, SRC_A};
         end
         SECT_UP_RIGHT, SECT_UP_LEFT: begin
            n = 4;
            xs = '{SRC_A, SRC_A, SRC_B, SRC_B, SRC_A, SRC_A};
            ys = '{SRC_A, SRC_B_UP, SRC_B_UP, SRC_B, SRC_A, SRC_A};
         end
         SECT_LEFT, SECT_DOWN_LEFT: begin
            n = 6;
            xs = '{SRC_A, SRC_A, SRC_B_UP, SRC_B_UP, SRC_B, SRC_B};
         end
         default: begin
            n = 6;
            xs = '{SRC_A, SRC_A, SRC_B_DN, SRC_B_DN, SRC_B, SRC_B};
         end
      endcase
      for (int k = 0; k < n; k++) begin
         w.point_x = coord_from(xs[k], x1, x2);
         w.point_y = coord_from(ys[k], y1, y2);
         w.is_move = (k == 0);
         w.last_point = (k == n - 1);
         w.bad_input = 1'b0;
         waypoints_due.push_back(w);
      end
   endfunction

   function automatic logic [IN_BITS-1:0] random_coord();
      int g;
      case ($urandom_range(5))
         0: return '0;
         1: return '1;
         2: begin
            g = $urandom_range(68) * GRID + $urandom_range(2) - 1;
            if (g < 0) g = 0;
            if (g > 4095) g = 4095;
            return IN_BITS'(g);
         end
         default: return IN_BITS'($urandom);
      endcase
   endfunction

   function automatic req_type random_request();
      req_type r;
      r.start_x = random_coord();
      r.start_y = random_coord();
      r.end_x = random_coord();
      r.end_y = random_coord();
      case ($urandom_range(9))
         0: begin
            r.end_x = r.start_x;
            r.end_y = r.start_y;
         end
         1: r.end_y = r.start_y;
         2: r.end_x = r.start_x;
         default: ;
      endcase
      return r;
   endfunction

   task automatic queue_request(input int sx, input int sy, input int ex, input int ey);
      req_type r;
      r.start_x = IN_BITS'(sx);
      r.start_y = IN_BITS'(sy);
      r.end_x = IN_BITS'(ex);
      r.end_y = IN_BITS'(ey);
      pending_requests.push_back(r);
   endtask

   task automatic wait_drained();
      while (pending_requests.size() != 0 || req_ch.valid || waypoints_due.size() != 0)
         @(negedge clock);
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.payload <= '0;
      end else if (!req_ch.valid || req_taken) begin
         if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_ch.valid <= 1'b1;
            req_ch.payload <= pending_requests.pop_front();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // response ready, with an occasional long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_served != holds_asked) begin
         rsp_ch.ready <= 1'b0;
         hold_left <= LONG_HOLD - 1;
         holds_served <= holds_served + 1;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // monitor, scoreboard and watchdog
   always @(posedge clock) begin
      rsp_type exp_w;
      rsp_type got_w;
      if (reset) begin
         req_taken <= 1'b0;
         quiet_cycles = 0;
      end else begin
         req_taken <= req_ch.valid && req_ch.ready;
         if (req_ch.valid && req_ch.ready) plan_route(req_ch.payload);
         if (req_ch.valid && !req_ch.ready) input_stalls++;
         if (rsp_ch.valid && rsp_ch.ready) begin
            got_w = rsp_ch.payload;
            if (waypoints_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected transfer x=%0d y=%0d move=%0b last=%0b bad=%0b",
                        $time, got_w.point_x, got_w.point_y, got_w.is_move,
                        got_w.last_point, got_w.bad_input);
            end else begin
               exp_w = waypoints_due.pop_front();
               waypoints_checked++;
               if (got_w.point_x !== exp_w.point_x || got_w.point_y !== exp_w.point_y ||
                   got_w.is_move !== exp_w.is_move || got_w.last_point !== exp_w.last_point ||
                   got_w.bad_input !== exp_w.bad_input) begin
                  errors++;
                  $display("%0t: mismatch expected x=%0d y=%0d move=%0b last=%0b bad=%0b",
                           $time, exp_w.point_x, exp_w.point_y, exp_w.is_move,
                           exp_w.last_point, exp_w.bad_input);
                  $display("%0t:          actual   x=%0d y=%0d move=%0b last=%0b bad=%0b",
                           $time, got_w.point_x, got_w.point_y, got_w.is_move,
                           got_w.last_point, got_w.bad_input);
               end
            end
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d waypoints outstanding",
                     $time, quiet_cycles, waypoints_due.size());
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      int send_pct[4];
      int recv_pct[4];
      send_pct = '{0, 88, 0, 30};
      recv_pct = '{0, 0, 88, 30};
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // axes, diagonals, coincident endpoints, grid edges, snap below zero
      queue_request(0, 0, 4095, 0);
      queue_request(4095, 0, 0, 0);
      queue_request(2000, 2000, 2000, 100);
      queue_request(100, 100, 100, 4095);
      queue_request(0, 4095, 4095, 0);
      queue_request(4095, 4095, 0, 0);
      queue_request(4095, 0, 0, 4095);
      queue_request(0, 0, 4095, 4095);
      queue_request(0, 0, 0, 0);
      queue_request(4095, 4095, 4095, 4095);
      queue_request(60, 60, 120, 60);
      queue_request(59, 61, 1, 4095);
      queue_request(1, 1, 60, 61);
      queue_request(4094, 4095, 4080, 4095);
      queue_request(0, 4095, 0, 0);
      queue_request(4080, 0, 4095, 4095);
      queue_request(1234, 3000, 1234, 3000);
      queue_request(61, 119, 0, 1);
      wait_drained();

      // receiver holds off while the sender keeps offering
      for (int i = 0; i < 24; i++) pending_requests.push_back(random_request());
      holds_asked = holds_asked + 1;
      wait_drained();

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = send_pct[p];
         recv_stall_pct = recv_pct[p];
         for (int i = 0; i < PHASE_ITEMS; i++) pending_requests.push_back(random_request());
         wait_drained();
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d connections (%0d coincident), %0d waypoints checked, %0d input stalls",
               connections, coincident, waypoints_checked, input_stalls);
      $display("sector hits R=%0d UR=%0d U=%0d UL=%0d L=%0d DL=%0d D=%0d DR=%0d",
               sector_hits[0], sector_hits[1], sector_hits[2], sector_hits[3],
               sector_hits[4], sector_hits[5], sector_hits[6], sector_hits[7]);
      if (errors == 0 && waypoints_due.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
